// ===== hdl/int_to_ascii_formatter_unit_macros.svh =====
// Assertion macros for the integer to ASCII formatter.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef INT_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define INT_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

// Base form: a complete property expression.
`define ITOAF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ITOAF_ASSERT_SAME(label, pre, post, msg) \
  `ITOAF_ASSERT(label, (pre) |-> (post), msg)

// The consequent must hold in the cycle after the antecedent.
`define ITOAF_ASSERT_NEXT(label, pre, post, msg) \
  `ITOAF_ASSERT(label, (pre) |=> (post), msg)

`endif

// ===== hdl/itoaf_pkg.sv =====
// Package for the integer to ASCII formatter: widths, radix codes, digit
// weight and character helpers. It depends on nothing else.
package itoaf_pkg;

  // Number of value bits that take part in the conversion.
  localparam int unsigned VALUE_BITS = 32;

  // Fixed widths of the item fields.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MINW_W   = 6;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned RADIX_W  = 2;
  localparam int unsigned S_DATA_W = ((VALUE_W + MINW_W + CHAR_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((CHAR_W + 7) / 8) * 8;

  // Digit position, restoring step and weight widths.
  localparam int unsigned POS_W    = $clog2(VALUE_BITS);
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned WEIGHT_W = VALUE_BITS + 4;

  // Radix selector codes; the remaining code produces no characters.
  typedef enum logic [RADIX_W-1:0] {
    RADIX_HEX = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_BIN = 2'd2
  } radix_e;

  // ASCII constants. The letter offset is 'a' - '9' - 1.
  localparam logic [CHAR_W-1:0] ASCII_ZERO        = 8'h30;
  localparam logic [CHAR_W-1:0] HEX_LETTER_OFFSET = 8'd39;
  localparam int unsigned       DEC_MAX_DIGITS    = 10;

  // Powers of ten used as decimal digit weights.
  function automatic logic [31:0] pow10(input int unsigned idx);
    logic [31:0] p;
    unique case (idx)
      0:       p = 32'd1;
      1:       p = 32'd10;
      2:       p = 32'd100;
      3:       p = 32'd1000;
      4:       p = 32'd10000;
      5:       p = 32'd100000;
      6:       p = 32'd1000000;
      7:       p = 32'd10000000;
      8:       p = 32'd100000000;
      default: p = 32'd1000000000;
    endcase
    return p;
  endfunction

  // Decimal digit count of the largest value, evaluated at elaboration.
  function automatic int unsigned dec_digits();
    logic [63:0] m;
    int unsigned n;
    m = (64'd1 << VALUE_BITS) - 64'd1;
    n = 1;
    for (int unsigned i = 1; i < DEC_MAX_DIGITS; i++) begin
      if (m >= 64'(pow10(i))) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int unsigned DEC_DIGITS = dec_digits();
  localparam int unsigned BIN_DIGITS = VALUE_BITS;

  // Hex and decimal resolve four digit bits, binary resolves one.
  localparam logic [STEP_W-1:0] STEP_WIDE   = 2'd3;
  localparam logic [STEP_W-1:0] STEP_NARROW = 2'd0;

  // Weight of bit k of the digit at a position: base^pos * 2^k.
  function automatic logic [WEIGHT_W-1:0] digit_weight(input radix_e r,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic [STEP_W-1:0] k);
    logic [WEIGHT_W-1:0] unit;
    unique case (r)
      RADIX_HEX: unit = WEIGHT_W'(1) << {pos, 2'b00};
      RADIX_DEC: unit = WEIGHT_W'(pow10(int'(pos)));
      RADIX_BIN: unit = WEIGHT_W'(1) << pos;
      default:   unit = '0;
    endcase
    return unit << k;
  endfunction

  // Lowercase ASCII character of one digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = ASCII_ZERO + CHAR_W'(d);
    if (d > 4'd9) begin
      c = c + HEX_LETTER_OFFSET;
    end
    return c;
  endfunction

endpackage

// ===== hdl/int_to_ascii_formatter_unit.sv =====
// Integer to ASCII formatter top level: one shared compare-subtract unit
// under a small sequencer. Depends on itoaf_pkg and the assertion macros.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: radix; tdata: value, min_width, fill_char
//  m_axis   | out       | tdata: out_char; tlast: last character of number
//
// Each digit bit is resolved by one compare-subtract against a weight from
// the package tables: four bits per hex or decimal digit, one per binary digit.
// An accepted number is converted one digit bit at a time, the compare-subtract
// unit being the limit; s_axis_tready is low until its final digit is done.
// A stalled m_axis holds the sequencer on the step that completes a digit.
// Reset clears the sequencer and the output valid flag; no clearing pass.
`include "int_to_ascii_formatter_unit_macros.svh"

module int_to_ascii_formatter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: value [31:0], min_width [37:32], fill_char [45:38].
  input  logic [itoaf_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: op (radix) [1:0].
  input  logic [itoaf_pkg::RADIX_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: out_char [7:0].
  output logic [itoaf_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_e;

  state_e                                state_q, state_d;
  itoaf_pkg::radix_e                     radix_q, radix_d;
  logic [itoaf_pkg::VALUE_BITS-1:0]      rem_q, rem_d;
  logic [itoaf_pkg::POS_W-1:0]           pos_q, pos_d;
  logic [itoaf_pkg::STEP_W-1:0]          step_q, step_d;
  logic [itoaf_pkg::DIGIT_W-1:0]         digit_q, digit_d;
  logic                                  lead_q, lead_d;
  logic [itoaf_pkg::MINW_W-1:0]          minw_q, minw_d;
  logic [itoaf_pkg::CHAR_W-1:0]          fill_q, fill_d;
  logic                                  out_valid_q, out_valid_d;
  logic [itoaf_pkg::CHAR_W-1:0]          out_char_q, out_char_d;
  logic                                  out_last_q, out_last_d;

  logic [itoaf_pkg::WEIGHT_W-1:0]        weight;
  logic [itoaf_pkg::WEIGHT_W:0]          diff;
  logic                                  take;
  logic [itoaf_pkg::DIGIT_W-1:0]         digit_new;
  logic                                  step_last;
  logic                                  is_final;
  logic                                  suppress;
  logic                                  use_fill;
  logic                                  emit;
  logic                                  slot_free;
  logic                                  stall;
  logic                                  load_out;
  logic                                  in_xfer;
  itoaf_pkg::radix_e                     in_radix;
  logic                                  in_radix_ok;

  // Shared compare-subtract unit: try to remove one weight from the remainder.
  assign weight    = itoaf_pkg::digit_weight(radix_q, pos_q, step_q);
  assign diff      = {1'b0, itoaf_pkg::WEIGHT_W'(rem_q)} - {1'b0, weight};
  assign take      = ~diff[itoaf_pkg::WEIGHT_W];
  assign digit_new = digit_q | (itoaf_pkg::DIGIT_W'(take) << step_q);

  // Decide what the finished digit prints: its character, the fill byte or nothing.
  assign step_last = (step_q == '0);
  assign is_final  = (pos_q == '0);
  assign suppress  = (digit_new == '0) && !lead_q && !is_final;
  assign use_fill  = suppress && (itoaf_pkg::MINW_W'(pos_q) < minw_q);
  assign emit      = !suppress || use_fill;

  // A character can enter the output register when it is empty or draining.
  assign slot_free = !out_valid_q || m_axis_tready;
  assign stall     = step_last && emit && !slot_free;
  assign load_out  = (state_q == ST_CALC) && step_last && emit && slot_free;

  // Input transfer decode.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_radix      = itoaf_pkg::radix_e'(s_axis_tuser);
  assign in_radix_ok   = (in_radix == itoaf_pkg::RADIX_HEX) ||
                         (in_radix == itoaf_pkg::RADIX_DEC) ||
                         (in_radix == itoaf_pkg::RADIX_BIN);

  // Sequencer: load a number, then walk digit positions and digit bits.
  always_comb begin
    state_d = state_q;
    radix_d = radix_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    step_d  = step_q;
    digit_d = digit_q;
    lead_d  = lead_q;
    minw_d  = minw_q;
    fill_d  = fill_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_radix_ok) begin
          state_d = ST_CALC;
          radix_d = in_radix;
          rem_d   = s_axis_tdata[itoaf_pkg::VALUE_BITS-1:0];
          minw_d  = s_axis_tdata[itoaf_pkg::VALUE_W +: itoaf_pkg::MINW_W];
          fill_d  = s_axis_tdata[itoaf_pkg::VALUE_W + itoaf_pkg::MINW_W +:
                                 itoaf_pkg::CHAR_W];
          digit_d = '0;
          lead_d  = 1'b0;
          unique case (in_radix)
            itoaf_pkg::RADIX_HEX: begin
              pos_d  = itoaf_pkg::POS_W'(itoaf_pkg::HEX_DIGITS - 1);
              step_d = itoaf_pkg::STEP_WIDE;
            end
            itoaf_pkg::RADIX_DEC: begin
              pos_d  = itoaf_pkg::POS_W'(itoaf_pkg::DEC_DIGITS - 1);
              step_d = itoaf_pkg::STEP_WIDE;
            end
            default: begin
              pos_d  = itoaf_pkg::POS_W'(itoaf_pkg::BIN_DIGITS - 1);
              step_d = itoaf_pkg::STEP_NARROW;
            end
          endcase
        end
      end
      ST_CALC: begin
        if (!stall) begin
          if (take) begin
            rem_d = diff[itoaf_pkg::VALUE_BITS-1:0];
          end
          if (!step_last) begin
            step_d  = step_q - 1'b1;
            digit_d = digit_new;
          end else begin
            digit_d = '0;
            lead_d  = lead_q || !suppress;
            if (is_final) begin
              state_d = ST_IDLE;
            end else begin
              pos_d  = pos_q - 1'b1;
              step_d = (radix_q == itoaf_pkg::RADIX_BIN) ? itoaf_pkg::STEP_NARROW
                                                          : itoaf_pkg::STEP_WIDE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds one character until its transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_char_d  = suppress ? fill_q : itoaf_pkg::digit_char(digit_new);
      out_last_d  = is_final;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    step_q     <= step_d;
    digit_q    <= digit_d;
    lead_q     <= lead_d;
    minw_q     <= minw_d;
    fill_q     <= fill_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = itoaf_pkg::M_DATA_W'(out_char_q);
  assign m_axis_tlast  = out_last_q;

  // The least significant character ends the number and frees the input.
  `ITOAF_ASSERT_NEXT(a_final_char_idles, load_out && is_final, state_q == ST_IDLE,
                     "sequencer did not return to idle after the final character")

  // The remainder always stays below twice the weight under test.
  `ITOAF_ASSERT_SAME(a_rem_bound, state_q == ST_CALC,
                     {1'b0, itoaf_pkg::WEIGHT_W'(rem_q)} < {weight, 1'b0},
                     "remainder exceeds the current digit range")

  // A decimal digit never resolves above nine.
  `ITOAF_ASSERT_SAME(a_dec_digit_range,
                     (state_q == ST_CALC) && (radix_q == itoaf_pkg::RADIX_DEC),
                     digit_new <= 4'd9,
                     "decimal digit out of range")

endmodule

// ===== bench/int_to_ascii_formatter_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for int_to_ascii_formatter_unit: drives numbers with radix,
// width and fill over s_axis and checks every character on m_axis against typed
// text or a behavioral model of it. Depends on itoaf_pkg and the formatter RTL.
module int_to_ascii_formatter_unit_tb;

  // The radix code that the block must swallow without output.
  localparam logic [itoaf_pkg::RADIX_W-1:0] RADIX_UNUSED = 2'd3;

  localparam int unsigned HEX_POSITIONS = 8;
  localparam int unsigned DEC_POSITIONS = 10;
  localparam int unsigned BIN_POSITIONS = 32;
  localparam logic [7:0]  CHAR_DIGIT_0  = 8'h30;
  localparam logic [7:0]  CHAR_LOWER_A  = 8'h61;

  localparam int unsigned RANDOM_PER_PHASE = 146;
  localparam int unsigned DRAIN_CYCLES     = 64;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;

  // One number to format.
  typedef struct packed {
    logic [itoaf_pkg::RADIX_W-1:0] op;
    logic [31:0]                   value;
    logic [5:0]                    min_width;
    logic [7:0]                    fill_char;
  } number_req_t;

  // One expected character of the text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [itoaf_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [itoaf_pkg::RADIX_W-1:0]    s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [itoaf_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                             m_axis_tlast;

  text_char_t  pending_text[$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // Directed rows; a typed row carries its text, the others use the model.
  number_req_t directed_req[$];
  bit          directed_typed[$];
  string       directed_text[$];

  int_to_ascii_formatter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Behavioral model: queues the characters that one number prints.
  function automatic void format_number(input number_req_t req);
    int          positions;
    int          pos;
    int          k;
    logic [31:0] digit;
    logic [31:0] weight;
    logic [7:0]  ch;
    bit          seen_digit;
    case (req.op)
      itoaf_pkg::RADIX_HEX: positions = HEX_POSITIONS;
      itoaf_pkg::RADIX_DEC: positions = DEC_POSITIONS;
      itoaf_pkg::RADIX_BIN: positions = BIN_POSITIONS;
      default:              return;
    endcase
    seen_digit = 1'b0;
    for (pos = positions - 1; pos >= 0; pos--) begin
      case (req.op)
        itoaf_pkg::RADIX_HEX: digit = (req.value >> (pos * 4)) & 32'hF;
        itoaf_pkg::RADIX_BIN: digit = (req.value >> pos) & 32'h1;
        default: begin
          weight = 32'd1;
          for (k = 0; k < pos; k++) weight = weight * 32'd10;
          digit = (req.value / weight) % 32'd10;
        end
      endcase
      // Leading zeros vanish unless the minimum width reaches them.
      if (digit == 0 && !seen_digit && pos > 0) begin
        if (pos >= int'(req.min_width)) continue;
        ch = req.fill_char;
      end else begin
        ch = (digit < 10) ? CHAR_DIGIT_0 + 8'(digit) : CHAR_LOWER_A + 8'(digit - 10);
        seen_digit = 1'b1;
      end
      pending_text.push_back('{ch: ch, last: (pos == 0)});
    end
  endfunction

  function automatic number_req_t random_number_req();
    number_req_t req;
    logic [31:0] p;
    int          k;
    int          n;
    // Mostly valid radixes, now and then the unused code.
    req.op = ($urandom_range(0, 15) == 0) ? RADIX_UNUSED
                                          : itoaf_pkg::RADIX_W'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: req.value = $urandom;
      1: req.value = $urandom >> $urandom_range(0, 31);
      2: req.value = $urandom_range(0, 99);
      default: begin
        // Near a power of ten, where decimal digit counts change.
        n = $urandom_range(0, 9);
        p = 32'd1;
        for (k = 0; k < n; k++) p = p * 32'd10;
        req.value = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
    endcase
    req.min_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32));
    case ($urandom_range(0, 2))
      0:       req.fill_char = " ";
      1:       req.fill_char = "0";
      default: req.fill_char = 8'($urandom_range(0, 255));
    endcase
    return req;
  endfunction

  // Offers one number after a random gap and queues its text on transfer.
  task automatic send_number(input number_req_t req, input bit typed, input string text);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.op;
    s_axis_tdata  <= itoaf_pkg::S_DATA_W'({req.fill_char, req.min_width, req.value});
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_text.push_back('{ch: text[i], last: (i == text.len() - 1)});
      end
    end else begin
      format_number(req);
    end
  endtask

  task automatic add_row(input logic [itoaf_pkg::RADIX_W-1:0] op,
                         input logic [31:0] value,
                         input logic [5:0] min_width, input logic [7:0] fill_char,
                         input bit typed, input string text);
    directed_req.push_back('{op: op, value: value, min_width: min_width,
                             fill_char: fill_char});
    directed_typed.push_back(typed);
    directed_text.push_back(text);
  endtask

  // Receiver: checks each character transfer, then picks the next ready.
  always @(posedge clk_i) begin : text_sink
    text_char_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_text.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing pending", m_axis_tdata));
        end else begin
          want = pending_text.pop_front();
          if (m_axis_tdata != want.ch) begin
            report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                      m_axis_tdata, want.ch));
          end
          if (m_axis_tlast != want.last) begin
            report_mismatch($sformatf("tlast %0b, wanted %0b", m_axis_tlast, want.last));
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Zero values, extremes, the unused radix, saturated widths and other width and fill cases.
    add_row(itoaf_pkg::RADIX_HEX, 32'h0000_0000,  6'd0,  " ",   1'b1, "0");
    add_row(itoaf_pkg::RADIX_DEC, 32'h0000_0000,  6'd0,  " ",   1'b1, "0");
    add_row(itoaf_pkg::RADIX_BIN, 32'h0000_0000,  6'd0,  " ",   1'b1, "0");
    add_row(itoaf_pkg::RADIX_HEX, 32'hFFFF_FFFF,  6'd0,  " ",   1'b1, "ffffffff");
    add_row(itoaf_pkg::RADIX_DEC, 32'hFFFF_FFFF,  6'd0,  " ",   1'b1, "4294967295");
    add_row(itoaf_pkg::RADIX_BIN, 32'hFFFF_FFFF,  6'd0,  " ",   1'b0, "");
    add_row(RADIX_UNUSED,         32'hFFFF_FFFF,  6'd63, 8'hFF, 1'b1, "");
    add_row(itoaf_pkg::RADIX_HEX, 32'h0000_0000,  6'd63, "*",   1'b1, "*******0");
    add_row(itoaf_pkg::RADIX_DEC, 32'h0000_0000,  6'd32, "#",   1'b1, "#########0");
    add_row(itoaf_pkg::RADIX_BIN, 32'h0000_0000,  6'd63, 8'hFF, 1'b0, "");
    add_row(itoaf_pkg::RADIX_HEX, 32'h0000_00AB,  6'd4,  "0",   1'b1, "00ab");
    add_row(itoaf_pkg::RADIX_DEC, 32'd1000000000, 6'd0,  " ",   1'b1, "1000000000");
    add_row(itoaf_pkg::RADIX_DEC, 32'd999999999,  6'd10, "0",   1'b1, "0999999999");
    add_row(itoaf_pkg::RADIX_BIN, 32'h8000_0000,  6'd0,  " ",   1'b0, "");
    add_row(itoaf_pkg::RADIX_BIN, 32'h0000_0001,  6'd8,  "0",   1'b1, "00000001");
    add_row(itoaf_pkg::RADIX_HEX, 32'hDEAD_BEEF,  6'd0,  " ",   1'b1, "deadbeef");
    add_row(itoaf_pkg::RADIX_HEX, 32'h0000_0100,  6'd2,  " ",   1'b1, "100");
    add_row(itoaf_pkg::RADIX_DEC, 32'd42,         6'd33, 8'h00, 1'b0, "");
    add_row(RADIX_UNUSED,         32'h0000_0000,  6'd0,  8'h00, 1'b1, "");
    add_row(itoaf_pkg::RADIX_HEX, 32'h1234_5678,  6'd9,  8'hAA, 1'b0, "");
    add_row(itoaf_pkg::RADIX_DEC, 32'd7,          6'd1,  " ",   1'b1, "7");

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles lightly while the receiver stalls often, then the
    // reverse, then both run flat out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 26; sink_stall_pct = 63; end
        1:       begin src_idle_pct = 63; sink_stall_pct = 26; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      if (phase == 0) begin
        for (int row = 0; row < directed_req.size(); row++) begin
          send_number(directed_req[row], directed_typed[row], directed_text[row]);
        end
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_number(random_number_req(), 1'b0, "");
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
